FILE: rtl/uart8n1_pkg.sv
// package: shared widths and reset values for the 8n1 uart core
`timescale 1ns / 1ps
package uart8n1_pkg;

  localparam int BYTE_W          = 8;
  localparam int CFG_W           = 16;
  localparam int DATA_BITS_DEF   = 8;
  localparam int TIMER_BITS_DEF  = 16;
  localparam logic [CFG_W-1:0] BIT_TIME_RST = 16'd104;

endpackage

FILE: rtl/uart8n1_in_if.sv
// interface: input channel carrying one transaction of tick, transmit request and pin level
`timescale 1ns / 1ps
interface uart8n1_in_if;

  logic                              valid;
  logic                              ready;
  logic                              tick;
  logic                              tx_start;
  logic [uart8n1_pkg::BYTE_W-1:0]    tx_byte;
  logic                              rx_line;

  modport source (output valid, output tick, output tx_start, output tx_byte,
                  output rx_line, input ready);
  modport sink   (input valid, input tick, input tx_start, input tx_byte,
                  input rx_line, output ready);

endinterface

FILE: rtl/uart8n1_out_if.sv
// interface: result channel carrying line levels, busy flags and received byte
`timescale 1ns / 1ps
interface uart8n1_out_if;

  logic                              valid;
  logic                              ready;
  logic                              tx_line;
  logic                              tx_busy;
  logic                              rx_busy;
  logic [uart8n1_pkg::BYTE_W-1:0]    rx_data;
  logic                              rx_valid;

  modport source (output valid, output tx_line, output tx_busy, output rx_busy,
                  output rx_data, output rx_valid, input ready);
  modport sink   (input valid, input tx_line, input tx_busy, input rx_busy,
                  input rx_data, input rx_valid, output ready);

endinterface

FILE: rtl/uart_8n1_transceiver_core.sv
// top level: 8n1 uart transmitter and receiver timed by a microsecond tick strobe
//
// usage:
// - in_ch carries one transaction per clock of the serial side: tick strobe,
//   transmit request with its byte, and the sampled receive pin level
// - out_ch returns exactly one transaction for every input transaction: the
//   transmit pin level, both busy flags, the last received byte and a
//   one-transaction pulse when a byte completes
// - cfg_we / cfg_wdata write the bit length in ticks; write only while idle
// - the state registers double as the result register, so a result appears
//   the cycle after its input transaction is taken
// - throughput is one transaction per cycle; in_ch.ready is high whenever the
//   result register is empty or being taken in the same cycle
// - when out_ch stalls, in_ch.ready drops and all timers and shifters hold,
//   so no serial time passes for the core until the result is taken
// - synchronous reset: both sides idle, transmit line high, received byte 0,
//   bit length 104 ticks, no result pending
// - transmit and receive paths are independent; each timer is a down-counter
//   reloaded from the bit length (1.5 bit lengths for the first rx sample)
`timescale 1ns / 1ps
module uart_8n1_transceiver_core #(
  parameter int DATA_BITS  = uart8n1_pkg::DATA_BITS_DEF,
  parameter int TIMER_BITS = uart8n1_pkg::TIMER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  uart8n1_in_if.sink                       in_ch,
  uart8n1_out_if.source                    out_ch,
  input  logic                             cfg_we,
  input  logic [uart8n1_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int CNT_W = $clog2(DATA_BITS + 3);
  localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam logic [CNT_W-1:0] LAST_DATA = CNT_W'(DATA_BITS);
  localparam logic [CNT_W-1:0] STOP_POS  = CNT_W'(DATA_BITS + 1);

  logic [uart8n1_pkg::CFG_W-1:0] bit_time_r;

  logic [DATA_BITS-1:0]  tx_shift_r,   tx_shift_nxt;
  logic [CNT_W-1:0]      tx_bit_cnt_r, tx_bit_cnt_nxt;
  logic [TIMER_BITS-1:0] tx_timer_r,   tx_timer_nxt;
  logic                  tx_active_r,  tx_active_nxt;
  logic                  tx_level_r,   tx_level_nxt;

  logic [DATA_BITS-1:0]  rx_shift_r,   rx_shift_nxt;
  logic [CNT_W-1:0]      rx_bit_cnt_r, rx_bit_cnt_nxt;
  logic [TIMER_BITS:0]   rx_timer_r,   rx_timer_nxt;
  logic                  rx_active_r,  rx_active_nxt;
  logic [DATA_BITS-1:0]  rx_hold_r,    rx_hold_nxt;
  logic                  rx_valid_r,   rx_valid_nxt;

  logic                  out_valid_r;
  logic                  in_ready;
  logic                  accept;
  logic [TIMER_BITS-1:0] bit_len;
  logic [CNT_W-1:0]      rx_idx;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // bit length saturated to the timer width
  generate
    if (TIMER_BITS >= uart8n1_pkg::CFG_W) begin : g_len_wide
      assign bit_len = TIMER_BITS'(bit_time_r);
    end else begin : g_len_sat
      localparam logic [uart8n1_pkg::CFG_W-1:0] TMAX =
        uart8n1_pkg::CFG_W'((64'd1 << TIMER_BITS) - 64'd1);
      assign bit_len = (bit_time_r > TMAX) ? '1 : bit_time_r[TIMER_BITS-1:0];
    end
  endgenerate

  // transmit side
  always_comb begin
    tx_shift_nxt   = tx_shift_r;
    tx_bit_cnt_nxt = tx_bit_cnt_r;
    tx_timer_nxt   = tx_timer_r;
    tx_active_nxt  = tx_active_r;
    tx_level_nxt   = tx_level_r;
    if (!tx_active_r) begin
      if (in_ch.tx_start) begin
        tx_active_nxt  = 1'b1;
        tx_level_nxt   = 1'b0;
        tx_shift_nxt   = DATA_BITS'(in_ch.tx_byte);
        tx_bit_cnt_nxt = '0;
        tx_timer_nxt   = bit_len;
      end
    end else if (in_ch.tick) begin
      if (tx_timer_r > TIMER_BITS'(1)) begin
        tx_timer_nxt = tx_timer_r - 1'b1;
      end else begin
        tx_bit_cnt_nxt = tx_bit_cnt_r + 1'b1;
        tx_timer_nxt   = bit_len;
        if (tx_bit_cnt_nxt <= LAST_DATA) begin
          tx_level_nxt = tx_shift_r[0];
          tx_shift_nxt = tx_shift_r >> 1;
        end else if (tx_bit_cnt_nxt == STOP_POS) begin
          tx_level_nxt = 1'b1;
        end else begin
          tx_active_nxt  = 1'b0;
          tx_level_nxt   = 1'b1;
          tx_bit_cnt_nxt = '0;
          tx_timer_nxt   = '0;
        end
      end
    end
  end

  // receive side
  always_comb begin
    rx_shift_nxt   = rx_shift_r;
    rx_bit_cnt_nxt = rx_bit_cnt_r;
    rx_timer_nxt   = rx_timer_r;
    rx_active_nxt  = rx_active_r;
    rx_hold_nxt    = rx_hold_r;
    rx_valid_nxt   = 1'b0;
    rx_idx         = rx_bit_cnt_r;
    if (!rx_active_r) begin
      if (!in_ch.rx_line) begin
        rx_active_nxt  = 1'b1;
        rx_bit_cnt_nxt = '0;
        rx_shift_nxt   = '0;
        // first sample lands mid-bit of the first data bit
        rx_timer_nxt   = {1'b0, bit_len} + {2'b00, bit_len[TIMER_BITS-1:1]};
      end
    end else if (in_ch.tick) begin
      if (rx_timer_r > (TIMER_BITS+1)'(1)) begin
        rx_timer_nxt = rx_timer_r - 1'b1;
      end else begin
        rx_bit_cnt_nxt = rx_bit_cnt_r + 1'b1;
        if (rx_bit_cnt_nxt <= LAST_DATA) begin
          rx_idx = rx_bit_cnt_r;
          rx_shift_nxt[rx_idx[IDX_W-1:0]] = in_ch.rx_line;
          rx_timer_nxt = {1'b0, bit_len};
        end else begin
          rx_active_nxt  = 1'b0;
          rx_bit_cnt_nxt = '0;
          rx_timer_nxt   = '0;
          rx_hold_nxt    = rx_shift_r;
          rx_valid_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_time_r   <= uart8n1_pkg::BIT_TIME_RST;
      tx_shift_r   <= '0;
      tx_bit_cnt_r <= '0;
      tx_timer_r   <= '0;
      tx_active_r  <= 1'b0;
      tx_level_r   <= 1'b1;
      rx_shift_r   <= '0;
      rx_bit_cnt_r <= '0;
      rx_timer_r   <= '0;
      rx_active_r  <= 1'b0;
      rx_hold_r    <= '0;
      rx_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        bit_time_r <= cfg_wdata;
      end
      if (accept) begin
        tx_shift_r   <= tx_shift_nxt;
        tx_bit_cnt_r <= tx_bit_cnt_nxt;
        tx_timer_r   <= tx_timer_nxt;
        tx_active_r  <= tx_active_nxt;
        tx_level_r   <= tx_level_nxt;
        rx_shift_r   <= rx_shift_nxt;
        rx_bit_cnt_r <= rx_bit_cnt_nxt;
        rx_timer_r   <= rx_timer_nxt;
        rx_active_r  <= rx_active_nxt;
        rx_hold_r    <= rx_hold_nxt;
        rx_valid_r   <= rx_valid_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tx_line  = tx_level_r;
  assign out_ch.tx_busy  = tx_active_r;
  assign out_ch.rx_busy  = rx_active_r;
  assign out_ch.rx_data  = uart8n1_pkg::BYTE_W'(rx_hold_r);
  assign out_ch.rx_valid = rx_valid_r;

  // a completed byte always leaves the receiver idle
  a_rx_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rx_valid_r |-> !rx_active_r)
    else $error("rx valid pulse while receiver still active");

  // idle transmitter holds the line high with a cleared counter
  a_tx_idle_line: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_active_r |-> (tx_level_r && tx_bit_cnt_r == '0))
    else $error("idle transmitter not parked");

  // transmit bit counter never passes the stop position
  a_tx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_bit_cnt_r <= STOP_POS)
    else $error("transmit bit counter out of range");

  // receive counter stays within the data bits while sampling
  a_rx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_bit_cnt_r <= LAST_DATA)
    else $error("receive bit counter out of range");

  // state only moves on an accepted transaction
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(tx_timer_r) && $stable(rx_timer_r) && $stable(rx_valid_r)))
    else $error("state changed without a transaction");

endmodule
